// ===== hdl/assert_macros.svh =====
// Assertion macros used by the light event table sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define WLET_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define WLET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/wlet_pkg.sv =====
// Types, codes and helpers of the weekly light event table.
package wlet_pkg;

  localparam int unsigned ENTRY_COUNT_DEF = 64;
  localparam int unsigned LIGHT_COUNT_DEF = 32;

  localparam logic [3:0] DAY_EVERYDAY = 4'd7;
  localparam logic [3:0] DAY_WEEKDAY  = 4'd8;
  localparam logic [3:0] DAY_WEEKEND  = 4'd9;
  localparam logic [2:0] DAY_SUNDAY   = 3'd0;
  localparam logic [2:0] DAY_MONDAY   = 3'd1;
  localparam logic [2:0] DAY_FRIDAY   = 3'd5;
  localparam logic [2:0] DAY_SATURDAY = 3'd6;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_WAKEUP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BAD_ID = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    KIND_STATUS  = 1'b0,
    KIND_COMMAND = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // One stored event.
  typedef struct packed {
    logic        action;
    logic [10:0] minute;
    logic [3:0]  day;
    logic [7:0]  light;
  } entry_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  light_id;
    logic [3:0]  day_code;
    logic [10:0] event_minute;
    logic        turn_on;
    logic [2:0]  current_day;
    logic [10:0] current_minute;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [7:0]  command_light;
    logic        command_on;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  // Memory access controls.
  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    entry_t wr_data;
  } mem_req_t;

  // Decide whether an entry's day code covers today.
  function automatic logic day_match(input logic [3:0] code, input logic [2:0] today);
    logic hit;
    hit = (code == DAY_EVERYDAY) || (code == {1'b0, today});
    if (code == DAY_WEEKEND && (today == DAY_SUNDAY || today == DAY_SATURDAY)) begin
      hit = 1'b1;
    end
    if (code == DAY_WEEKDAY && today >= DAY_MONDAY && today <= DAY_FRIDAY) begin
      hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== hdl/wlet_mem.sv =====
// Entry memory: one write port, one read port with registered read data.
module wlet_mem #(
  parameter int unsigned DEPTH = wlet_pkg::ENTRY_COUNT_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  wlet_pkg::mem_req_t req_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [AW-1:0]      rd_addr_i,
  output wlet_pkg::entry_t   rd_data_o
);

  wlet_pkg::entry_t mem_q [DEPTH];
  wlet_pkg::entry_t rd_data_q;

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= req_i.wr_data;
    end
  end

  // Read the entry, hold the data between reads
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/wlet_ctrl.sv =====
// Table sequencer: valid bits, entry scan and result hand-off.
`include "assert_macros.svh"

module wlet_ctrl #(
  parameter int unsigned ENTRY_COUNT = wlet_pkg::ENTRY_COUNT_DEF,
  parameter int unsigned LIGHT_COUNT = wlet_pkg::LIGHT_COUNT_DEF,
  parameter int unsigned AW          = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wlet_pkg::item_t    item_i,
  output wlet_pkg::mem_req_t mem_req_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [AW-1:0]      rd_addr_o,
  input  wlet_pkg::entry_t   rd_data_i,
  input  logic               out_free_i,
  output wlet_pkg::push_t    push_o
);

  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRY_COUNT - 1);
  localparam logic [8:0]    LIGHT_LIM = 9'(LIGHT_COUNT);

  wlet_pkg::state_e  state_q, state_d;
  wlet_pkg::item_t   item_q;
  logic [AW-1:0]     idx_q, idx_d;
  logic              rd_more_q, rd_more_d;
  logic              cmp_v_q, cmp_v_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              valid_q [ENTRY_COUNT];
  logic              valid_d [ENTRY_COUNT];
  logic              pend_v_q, pend_v_d;
  wlet_pkg::result_t pend_q, pend_d;

  logic entry_live;
  logic wake_hit;
  logic remove_hit;
  logic stall;

  // Compare the entry that came back from memory
  assign entry_live = cmp_v_q && valid_q[cmp_idx_q];
  assign wake_hit = entry_live
                 && wlet_pkg::day_match(rd_data_i.day, item_q.current_day)
                 && (rd_data_i.minute == item_q.current_minute);
  assign remove_hit = entry_live
                   && (rd_data_i.light == item_q.light_id)
                   && (rd_data_i.day == item_q.day_code)
                   && (rd_data_i.minute == item_q.event_minute);
  assign stall = (wlet_pkg::op_e'(item_q.operation) == wlet_pkg::OP_WAKEUP)
              && wake_hit && pend_v_q && !out_free_i;

  assign wr_addr_o = idx_q;
  assign rd_addr_o = idx_q;

  // Next state, table updates and result pushes
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rd_more_d  = rd_more_q;
    cmp_v_d    = cmp_v_q;
    cmp_idx_d  = cmp_idx_q;
    valid_d    = valid_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    mem_req_o  = '0;
    push_o     = '0;
    mem_req_o.wr_data = '{action: item_q.turn_on, minute: item_q.event_minute,
                          day: item_q.day_code, light: item_q.light_id};

    unique case (state_q)
      wlet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d     = '0;
          rd_more_d = 1'b1;
          cmp_v_d   = 1'b0;
          pend_d    = '0;
          case (wlet_pkg::op_e'(item_i.operation))
            wlet_pkg::OP_SCHEDULE: begin
              if ({1'b0, item_i.light_id} >= LIGHT_LIM) begin
                pend_v_d      = 1'b1;
                pend_d.status = wlet_pkg::STATUS_BAD_ID;
                state_d       = wlet_pkg::ST_FINISH;
              end else begin
                state_d = wlet_pkg::ST_SCAN;
              end
            end
            wlet_pkg::OP_REMOVE: begin
              pend_v_d      = 1'b1;
              pend_d.status = wlet_pkg::STATUS_OK;
              state_d       = wlet_pkg::ST_SCAN;
            end
            wlet_pkg::OP_WAKEUP: begin
              state_d = wlet_pkg::ST_SCAN;
            end
            default: begin
              state_d = wlet_pkg::ST_FINISH;
            end
          endcase
        end
      end

      wlet_pkg::ST_SCAN: begin
        if (wlet_pkg::op_e'(item_q.operation) == wlet_pkg::OP_SCHEDULE) begin
          // Walk the valid bits for the first free entry
          if (!valid_q[idx_q]) begin
            mem_req_o.wr_en = 1'b1;
            valid_d[idx_q]  = 1'b1;
            pend_v_d        = 1'b1;
            pend_d.status   = wlet_pkg::STATUS_OK;
            state_d         = wlet_pkg::ST_FINISH;
          end else if (idx_q == LAST_IDX) begin
            pend_v_d      = 1'b1;
            pend_d.status = wlet_pkg::STATUS_FULL;
            state_d       = wlet_pkg::ST_FINISH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (!stall) begin
          // Advance the read pipeline one entry
          mem_req_o.rd_en = rd_more_q;
          cmp_v_d         = rd_more_q;
          cmp_idx_d       = idx_q;
          if (rd_more_q) begin
            idx_d     = idx_q + 1'b1;
            rd_more_d = (idx_q != LAST_IDX);
          end
          if (wlet_pkg::op_e'(item_q.operation) == wlet_pkg::OP_REMOVE) begin
            if (remove_hit) begin
              valid_d[cmp_idx_q] = 1'b0;
            end
          end else if (wake_hit) begin
            // Release the held command, hold the new one until more follow
            if (pend_v_q) begin
              push_o.valid    = 1'b1;
              push_o.res      = pend_q;
              push_o.res.last = 1'b0;
            end
            pend_v_d             = 1'b1;
            pend_d               = '0;
            pend_d.result_kind   = wlet_pkg::KIND_COMMAND;
            pend_d.command_light = rd_data_i.light;
            pend_d.command_on    = rd_data_i.action;
          end
          if (!rd_more_q && !cmp_v_q) begin
            state_d = wlet_pkg::ST_FINISH;
          end
        end
      end

      wlet_pkg::ST_FINISH: begin
        // Send the final result marked last
        if (pend_v_q) begin
          if (out_free_i) begin
            push_o.valid    = 1'b1;
            push_o.res      = pend_q;
            push_o.res.last = 1'b1;
            pend_v_d        = 1'b0;
            state_d         = wlet_pkg::ST_IDLE;
          end
        end else begin
          state_d = wlet_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wlet_pkg::ST_IDLE;
      rd_more_q <= 1'b0;
      cmp_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      valid_q   <= '{default: 1'b0};
    end else begin
      state_q   <= state_d;
      rd_more_q <= rd_more_d;
      cmp_v_q   <= cmp_v_d;
      pend_v_q  <= pend_v_d;
      valid_q   <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    pend_q    <= pend_d;
  end

  `WLET_ASSERT(a_idle_empty, clk_i, rst_ni, (state_q == wlet_pkg::ST_IDLE) |-> !pend_v_q, "pending result left in idle")
  `WLET_ASSERT(a_push_free, clk_i, rst_ni, push_o.valid |-> out_free_i, "result pushed into a full output register")
  `WLET_ASSERT(a_cmp_in_scan, clk_i, rst_ni, cmp_v_q |-> (state_q == wlet_pkg::ST_SCAN), "compare stage busy outside scan")
  `WLET_ASSERT_NEXT(a_accept_leaves, clk_i, rst_ni, (state_q == wlet_pkg::ST_IDLE) && in_valid_i, state_q != wlet_pkg::ST_IDLE, "accepted item did not start")

endmodule

// ===== hdl/weekly_light_event_table_core.sv =====
// Schedule answers after walking the valid bits for the first free entry.
// Remove and wakeup read every entry through the single memory read port,
// and wait whenever the output side stalls.
// Throughput: one item at a time; the next beat is taken once the last result is queued.
// Reset clears the valid bits at once; entry memory is not cleared and needs no pass.
module weekly_light_event_table_core #(
  parameter int unsigned ENTRY_COUNT = wlet_pkg::ENTRY_COUNT_DEF,
  parameter int unsigned LIGHT_COUNT = wlet_pkg::LIGHT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // light_id[7:0], day_code[11:8], event_minute[22:12], turn_on[23],
  // current_day[26:24], current_minute[37:27], zero fill[39:38]
  input  logic [39:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], command_light[9:2], command_on[10], zero fill[15:11]
  output logic [15:0] m_axis_tdata,
  // result_kind[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  wlet_pkg::item_t    item;
  wlet_pkg::mem_req_t mem_req;
  wlet_pkg::entry_t   rd_data;
  wlet_pkg::push_t    push;
  wlet_pkg::result_t  out_res_q;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               out_v_q;
  logic               out_free;

  // Unpack the input beat
  assign item.operation      = s_axis_tuser;
  assign item.light_id       = s_axis_tdata[7:0];
  assign item.day_code       = s_axis_tdata[11:8];
  assign item.event_minute   = s_axis_tdata[22:12];
  assign item.turn_on        = s_axis_tdata[23];
  assign item.current_day    = s_axis_tdata[26:24];
  assign item.current_minute = s_axis_tdata[37:27];

  wlet_ctrl #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .LIGHT_COUNT(LIGHT_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .item_i    (item),
    .mem_req_o (mem_req),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .out_free_i(out_free),
    .push_o    (push)
  );

  wlet_mem #(
    .DEPTH(ENTRY_COUNT),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .wr_addr_i(wr_addr),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Output register: free when empty or being taken
  assign out_free = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (push.valid) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_res_q <= push.res;
    end
  end

  // Pack the output beat
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_res_q.command_on, out_res_q.command_light,
                          out_res_q.status};
  assign m_axis_tuser  = out_res_q.result_kind;
  assign m_axis_tlast  = out_res_q.last;

endmodule

// ===== test/weekly_light_event_table_core_test.sv =====
// Stream testbench for the weekly light event table: schedule, remove and wakeup beats.
`timescale 1ns / 1ps

module weekly_light_event_table_core_test;

  localparam int TABLE_DEPTH = wlet_pkg::ENTRY_COUNT_DEF;
  localparam int LIGHT_LIMIT = wlet_pkg::LIGHT_COUNT_DEF;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam logic [2:0] DAY_WEDNESDAY = 3'd3;
  localparam logic [2:0] DAY_THURSDAY = 3'd4;
  localparam logic [2:0] DAY_TODAY_NONE = 3'd7;
  localparam logic [3:0] DAY_CODE_BAD = 4'd15;
  localparam logic [10:0] FILL_MINUTE = 11'd5;
  localparam int MAX_REPORTS = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Shadow copy of the event table
  logic        tbl_valid [TABLE_DEPTH];
  logic [7:0]  tbl_light [TABLE_DEPTH];
  logic [3:0]  tbl_day [TABLE_DEPTH];
  logic [10:0] tbl_minute [TABLE_DEPTH];
  logic        tbl_action [TABLE_DEPTH];

  wlet_pkg::item_t   pending_items[$];
  wlet_pkg::item_t   scheduled_log[$];
  wlet_pkg::result_t expected_results[$];

  int unsigned beats_sent = 0;
  int unsigned beats_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  weekly_light_event_table_core #(
    .ENTRY_COUNT(TABLE_DEPTH),
    .LIGHT_COUNT(LIGHT_LIMIT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Decide whether a stored day code is due today
  function automatic logic due_today(input logic [3:0] code, input logic [2:0] today);
    return (code == wlet_pkg::DAY_EVERYDAY) || (code == {1'b0, today}) ||
           (code == wlet_pkg::DAY_WEEKEND &&
            (today == wlet_pkg::DAY_SUNDAY || today == wlet_pkg::DAY_SATURDAY)) ||
           (code == wlet_pkg::DAY_WEEKDAY &&
            today >= wlet_pkg::DAY_MONDAY && today <= wlet_pkg::DAY_FRIDAY);
  endfunction

  // Update the shadow table and queue the results one accepted beat causes
  task automatic apply_event(input wlet_pkg::item_t it);
    wlet_pkg::result_t r;
    wlet_pkg::result_t held;
    int slot;
    logic have_held;
    r = '0;
    r.result_kind = wlet_pkg::KIND_STATUS;
    r.last = 1'b1;
    have_held = 1'b0;
    held = '0;
    slot = -1;
    case (it.operation)
      wlet_pkg::OP_SCHEDULE: begin
        if (it.light_id >= LIGHT_LIMIT) begin
          r.status = wlet_pkg::STATUS_BAD_ID;
        end else begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot < 0 && !tbl_valid[i]) begin
              slot = i;
            end
          end
          if (slot < 0) begin
            r.status = wlet_pkg::STATUS_FULL;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_light[slot] = it.light_id;
            tbl_day[slot] = it.day_code;
            tbl_minute[slot] = it.event_minute;
            tbl_action[slot] = it.turn_on;
            r.status = wlet_pkg::STATUS_OK;
          end
        end
        expected_results.push_back(r);
      end
      wlet_pkg::OP_REMOVE: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && tbl_light[i] == it.light_id && tbl_day[i] == it.day_code &&
              tbl_minute[i] == it.event_minute) begin
            tbl_valid[i] = 1'b0;
          end
        end
        r.status = wlet_pkg::STATUS_OK;
        expected_results.push_back(r);
      end
      wlet_pkg::OP_WAKEUP: begin
        // Hold each command back one step so the final one gets the last flag
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && due_today(tbl_day[i], it.current_day) &&
              tbl_minute[i] == it.current_minute) begin
            if (have_held) begin
              expected_results.push_back(held);
            end
            held = '0;
            held.result_kind = wlet_pkg::KIND_COMMAND;
            held.status = wlet_pkg::STATUS_OK;
            held.command_light = tbl_light[i];
            held.command_on = tbl_action[i];
            have_held = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          expected_results.push_back(held);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input wlet_pkg::result_t want,
                               input wlet_pkg::result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected kind %0d status %0d light %0d on %0d last %0d",
               $realtime, what, want.result_kind, want.status, want.command_light,
               want.command_on, want.last);
      $display("%0t: %s: got kind %0d status %0d light %0d on %0d last %0d",
               $realtime, what, got.result_kind, got.status, got.command_light,
               got.command_on, got.last);
    end
  endtask

  task automatic check_beat(input wlet_pkg::result_t got);
    wlet_pkg::result_t want;
    if (expected_results.size() == 0) begin
      note_mismatch("result with nothing pending", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.result_kind !== want.result_kind) note_mismatch("kind", want, got);
      else if (got.status !== want.status) note_mismatch("status", want, got);
      else if (got.command_light !== want.command_light) note_mismatch("light", want, got);
      else if (got.command_on !== want.command_on) note_mismatch("action", want, got);
      else if (got.last !== want.last) note_mismatch("last", want, got);
    end
  endtask

  // Sample both handshakes; the input side goes first so expectations stay in order
  always @(posedge clk_i) begin : beat_monitor
    wlet_pkg::item_t   in_beat;
    wlet_pkg::result_t out_beat;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_beat.operation = s_axis_tuser;
        in_beat.light_id = s_axis_tdata[7:0];
        in_beat.day_code = s_axis_tdata[11:8];
        in_beat.event_minute = s_axis_tdata[22:12];
        in_beat.turn_on = s_axis_tdata[23];
        in_beat.current_day = s_axis_tdata[26:24];
        in_beat.current_minute = s_axis_tdata[37:27];
        apply_event(in_beat);
        beats_taken <= beats_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_beat.result_kind = m_axis_tuser;
        out_beat.status = m_axis_tdata[1:0];
        out_beat.command_light = m_axis_tdata[9:2];
        out_beat.command_on = m_axis_tdata[10];
        out_beat.last = m_axis_tlast;
        check_beat(out_beat);
      end
    end
  end

  // Feed beats from the pending queue; hold a beat until it is taken
  always @(negedge clk_i) begin : event_driver
    wlet_pkg::item_t it;
    logic            next_valid;
    if (rst_ni) begin
      next_valid = s_axis_tvalid;
      if (beats_sent == beats_taken) begin
        next_valid = 1'b0;
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          s_axis_tdata <= {2'b00, it.current_minute, it.current_day, it.turn_on,
                           it.event_minute, it.day_code, it.light_id};
          s_axis_tuser <= it.operation;
          beats_sent++;
          next_valid = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic add_event(input logic [1:0] op, input logic [7:0] light,
                           input logic [3:0] day, input logic [10:0] minute,
                           input logic on, input logic [2:0] today,
                           input logic [10:0] now);
    wlet_pkg::item_t it;
    it.operation = op;
    it.light_id = light;
    it.day_code = day;
    it.event_minute = minute;
    it.turn_on = on;
    it.current_day = today;
    it.current_minute = now;
    pending_items.push_back(it);
  endtask

  // Minutes cluster on a few values so wakeups find due entries
  function automatic logic [10:0] pick_minute();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0, 1: return 11'd0;
      2, 3: return FILL_MINUTE;
      4:    return 11'd720;
      5:    return 11'd1439;
      6, 7, 8: return 11'($urandom_range(1439));
      default: return 11'($urandom_range(2047));
    endcase
  endfunction

  task automatic queue_random_events(input int count);
    wlet_pkg::item_t it;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      it.light_id = ($urandom_range(99) < 85) ? 8'($urandom_range(LIGHT_LIMIT - 1))
                                               : 8'($urandom_range(255));
      it.day_code = ($urandom_range(99) < 85) ? 4'($urandom_range(9))
                                               : 4'($urandom_range(15));
      it.event_minute = pick_minute();
      it.turn_on = 1'($urandom_range(1));
      it.current_day = 3'($urandom_range(7));
      it.current_minute = pick_minute();
      if (pick < 45) begin
        it.operation = wlet_pkg::OP_SCHEDULE;
        scheduled_log.push_back(it);
        if (scheduled_log.size() > 128) void'(scheduled_log.pop_front());
      end else if (pick < 65) begin
        // Mostly remove something that was scheduled before
        if (scheduled_log.size() != 0 && $urandom_range(9) < 7) begin
          it = scheduled_log[$urandom_range(scheduled_log.size() - 1)];
        end
        it.operation = wlet_pkg::OP_REMOVE;
      end else if (pick < 95) begin
        // Wakeups often hit the time of a known event
        if (scheduled_log.size() != 0 && $urandom_range(9) < 5) begin
          it.current_minute =
            scheduled_log[$urandom_range(scheduled_log.size() - 1)].event_minute;
        end
        it.operation = wlet_pkg::OP_WAKEUP;
      end else begin
        it.operation = OP_UNKNOWN;
      end
      pending_items.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || beats_sent != beats_taken ||
           expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_light[i] = '0;
      tbl_day[i] = '0;
      tbl_minute[i] = '0;
      tbl_action[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty wakeup, field extremes, day codes, removes, ignored op
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, wlet_pkg::DAY_SUNDAY, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd0, {1'b0, wlet_pkg::DAY_SUNDAY}, 11'd0, 1'b1,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd31, wlet_pkg::DAY_EVERYDAY, 11'd1439, 1'b0,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd32, wlet_pkg::DAY_EVERYDAY, 11'd0, 1'b1,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd255, DAY_CODE_BAD, 11'd2047, 1'b1, 3'd7, 11'd2047);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd5, wlet_pkg::DAY_WEEKDAY, 11'd100, 1'b1,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd6, wlet_pkg::DAY_WEEKEND, 11'd100, 1'b0,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd7, DAY_CODE_BAD, 11'd100, 1'b1, 3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd8, wlet_pkg::DAY_EVERYDAY, 11'd2047, 1'b1,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd9, {1'b0, DAY_WEDNESDAY}, 11'd100, 1'b0,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd10, wlet_pkg::DAY_EVERYDAY, 11'd100, 1'b1,
              3'd0, 11'd0);
    add_event(OP_UNKNOWN, 8'd255, 4'd15, 11'd2047, 1'b1, 3'd7, 11'd2047);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, wlet_pkg::DAY_SUNDAY, 11'd0);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, DAY_WEDNESDAY, 11'd100);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, wlet_pkg::DAY_SATURDAY,
              11'd100);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, DAY_TODAY_NONE, 11'd100);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, DAY_THURSDAY, 11'd2047);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, wlet_pkg::DAY_FRIDAY,
              11'd1439);
    add_event(wlet_pkg::OP_REMOVE, 8'd5, wlet_pkg::DAY_WEEKDAY, 11'd100, 1'b0,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_REMOVE, 8'd5, wlet_pkg::DAY_WEEKDAY, 11'd101, 1'b0,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, wlet_pkg::DAY_MONDAY, 11'd100);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd12, {1'b0, DAY_THURSDAY}, 11'd200, 1'b1,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_SCHEDULE, 8'd12, {1'b0, DAY_THURSDAY}, 11'd200, 1'b0,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_REMOVE, 8'd12, {1'b0, DAY_THURSDAY}, 11'd200, 1'b0,
              3'd0, 11'd0);
    add_event(wlet_pkg::OP_WAKEUP, 8'd0, 4'd0, 11'd0, 1'b0, DAY_THURSDAY, 11'd200);
    queue_random_events(45);
    wait_drained();

    // Receiver stalls: fill the table past full, then fire every entry it added at once
    sink_stall_pct = 75;
    repeat (TABLE_DEPTH + 2) begin
      add_event(wlet_pkg::OP_SCHEDULE, 8'($urandom_range(7)), wlet_pkg::DAY_EVERYDAY,
                FILL_MINUTE, 1'($urandom_range(1)), 3'($urandom_range(7)),
                11'($urandom_range(2047)));
    end
    add_event(wlet_pkg::OP_WAKEUP, 8'($urandom_range(255)), 4'($urandom_range(15)),
              11'($urandom_range(2047)), 1'($urandom_range(1)), 3'($urandom_range(7)),
              FILL_MINUTE);
    for (int l = 0; l < 8; l++) begin
      add_event(wlet_pkg::OP_REMOVE, 8'(l), wlet_pkg::DAY_EVERYDAY, FILL_MINUTE, 1'b0,
                3'd0, 11'd0);
    end
    queue_random_events(45);
    wait_drained();

    send_idle_pct = 75;
    sink_stall_pct = 0;
    queue_random_events(40);
    wait_drained();

    send_idle_pct = 9;
    sink_stall_pct = 9;
    queue_random_events(40);
    wait_drained();

    // Let any scan still running finish before the verdict
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
